// File: rtl/core/awla_pkg.sv
`default_nettype none

package awla_pkg;

  // Opcodes of an input item
  localparam logic [2:0] OP_SIGNAL         = 3'd0;
  localparam logic [2:0] OP_WAIT_LT        = 3'd1;
  localparam logic [2:0] OP_WAIT_LT_TO     = 3'd2;
  localparam logic [2:0] OP_DEC_WAIT_LT    = 3'd3;
  localparam logic [2:0] OP_DEC_WAIT_LT_TO = 3'd4;
  localparam logic [2:0] OP_TIMEOUT        = 3'd5;

  // Result status codes
  localparam logic [1:0] STS_SUCCESS = 2'd0;
  localparam logic [1:0] STS_TIMEOUT = 2'd1;
  localparam logic [1:0] STS_INVALID = 2'd2;
  localparam logic [1:0] STS_FULL    = 2'd3;

  // Wake limit per signal and the width of its counter
  localparam int MAX_RESULTS = 16;
  localparam int WAKE_CNT_W  = $clog2(MAX_RESULTS + 1);

  typedef struct packed {
    logic [2:0]         opcode;
    logic [7:0]         thread_id;
    logic [5:0]         thread_priority;
    logic [31:0]        address;
    logic signed [31:0] compare_value;
    logic signed [31:0] memory_word;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               thread_waits;
    logic               memory_write;
    logic signed [31:0] memory_write_value;
    logic               woken_valid;
    logic [7:0]         woken_thread;
    logic               last;
  } out_item_t;

  // Fixed-width part of one wait slot
  typedef struct packed {
    logic [7:0]  thread;
    logic [31:0] address;
    logic [5:0]  prio;
  } slot_data_t;

  // Selection rule of one scan pass
  typedef enum logic [1:0] {
    PM_FREE,
    PM_THREAD,
    PM_PRIO,
    PM_ARRIVAL
  } pick_mode_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_LAST,
    S_DECIDE
  } state_t;

  // Sequencer to pick unit
  typedef struct packed {
    logic       clear;
    pick_mode_t mode;
    logic       pick_en;
    logic       dec_en;
  } pick_ctl_t;

  // Sequencer to slot store
  typedef struct packed {
    logic rd_en;
    logic ins_en;
    logic clr_en;
  } store_cmd_t;

endpackage

`default_nettype wire

// File: rtl/core/awla_slot_store.sv
`default_nettype none

module awla_slot_store #(
  parameter int WAIT_SLOTS = 16,
  localparam int IdxW = $clog2(WAIT_SLOTS)
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  awla_pkg::store_cmd_t    cmd,
  input  wire  [IdxW-1:0]         rd_idx,
  input  wire  [IdxW-1:0]         ins_idx,
  input  awla_pkg::slot_data_t    ins_data,
  input  wire  [IdxW-1:0]         ins_rank,
  input  wire  [IdxW-1:0]         clr_idx,
  input  wire                     wb_en,
  input  wire  [IdxW-1:0]         wb_idx,
  input  wire  [IdxW-1:0]         wb_rank,
  output logic                    rd_vld_r,
  output logic [IdxW-1:0]         rd_idx_r,
  output logic                    rd_valid_bit_r,
  output awla_pkg::slot_data_t    rd_data_r,
  output logic [IdxW-1:0]         rd_rank_r
);

  logic [WAIT_SLOTS-1:0] valid_r;
  awla_pkg::slot_data_t  data_mem [WAIT_SLOTS];
  logic [IdxW-1:0]       rank_mem [WAIT_SLOTS];

  // Valid bits: set on insert, cleared on removal
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (cmd.ins_en) begin
        valid_r[ins_idx] <= 1'b1;
      end
      if (cmd.clr_en) begin
        valid_r[clr_idx] <= 1'b0;
      end
    end
  end

  // Slot payload memory
  always_ff @(posedge clk) begin
    if (cmd.ins_en) begin
      data_mem[ins_idx] <= ins_data;
    end
  end

  // Arrival rank memory: insert or rank write-back during a pass
  always_ff @(posedge clk) begin
    if (cmd.ins_en) begin
      rank_mem[ins_idx] <= ins_rank;
    end else if (wb_en) begin
      rank_mem[wb_idx] <= wb_rank;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data_r      <= data_mem[rd_idx];
      rd_rank_r      <= rank_mem[rd_idx];
      rd_valid_bit_r <= valid_r[rd_idx];
      rd_idx_r       <= rd_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.rd_en;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/awla_pick_unit.sv
`default_nettype none

module awla_pick_unit #(
  parameter int WAIT_SLOTS = 16,
  localparam int IdxW = $clog2(WAIT_SLOTS)
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  awla_pkg::pick_ctl_t     ctl,
  input  wire                     data_vld,
  input  wire  [IdxW-1:0]         rd_idx,
  input  wire                     e_valid,
  input  awla_pkg::slot_data_t    e_data,
  input  wire  [IdxW-1:0]         e_rank,
  input  wire  [31:0]             key_address,
  input  wire  [7:0]              key_thread,
  input  wire  [IdxW-1:0]         dec_rank,
  output logic                    found_r,
  output logic [IdxW-1:0]         best_idx_r,
  output awla_pkg::slot_data_t    best_data_r,
  output logic [IdxW-1:0]         best_rank_r,
  output logic                    wb_en,
  output logic [IdxW-1:0]         wb_rank
);

  logic            dec_hit;
  logic [IdxW-1:0] adj_rank;
  logic            cand;
  logic            better;
  logic            take;

  // Close the rank gap left by the previous removal
  always_comb begin
    dec_hit  = data_vld && e_valid && ctl.dec_en && (e_rank > dec_rank);
    adj_rank = dec_hit ? (e_rank - IdxW'(1)) : e_rank;
    wb_en    = dec_hit;
    wb_rank  = adj_rank;
  end

  // Candidate match and ordering against the current best
  always_comb begin
    unique case (ctl.mode) inside
      awla_pkg::PM_FREE:   cand = !e_valid;
      awla_pkg::PM_THREAD: cand = e_valid && (e_data.thread == key_thread);
      awla_pkg::PM_PRIO, awla_pkg::PM_ARRIVAL:
                           cand = e_valid && (e_data.address == key_address);
      default:             cand = 1'b0;
    endcase

    if (!found_r) begin
      better = 1'b1;
    end else begin
      case (ctl.mode)
        awla_pkg::PM_PRIO: begin
          if (e_data.prio != best_data_r.prio) begin
            better = e_data.prio < best_data_r.prio;
          end else begin
            better = adj_rank < best_rank_r;
          end
        end
        awla_pkg::PM_ARRIVAL: better = adj_rank < best_rank_r;
        default:              better = 1'b0;
      endcase
    end

    take = data_vld && ctl.pick_en && cand && better;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (ctl.clear) begin
      found_r <= 1'b0;
    end else if (take) begin
      found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best_idx_r  <= rd_idx;
      best_data_r <= e_data;
      best_rank_r <= adj_rank;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/address_wait_list_arbiter_unit.sv
`default_nettype none

// Address wait-list arbiter.
// An item is transferred at a clock edge with start high and busy low.
// Results leave on out_item for one cycle each, marked by out_valid; the
// receiver cannot stall, so no result is ever held back. out_item.last
// flags the final result of an item.
// Invalid opcodes and waits whose compare fails answer in the cycle after
// start and never raise busy.
// Every other item runs scan passes over the wait slots. A pass reads one
// slot per cycle through the slot store's single read port, then waits for
// the last read to reach the pick unit, then decides; the shared pick unit
// compares each slot read. A queued wait takes one pass.
// A signal waking k threads, or a timeout event removing k entries, takes
// k + 1 passes; the extra pass closes the arrival-rank gap of the last
// removal. Woken threads come out one per pass, at most 16 per signal.
// Reset (rst_n low, synchronous) empties the wait list at once through
// the slot valid bits; slot memories are not cleared.
module address_wait_list_arbiter_unit #(
  parameter int WAIT_SLOTS = 16
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   start,
  output logic                  busy,
  input  awla_pkg::in_item_t    in_item,
  output logic                  out_valid,
  output awla_pkg::out_item_t   out_item
);

  localparam int IdxW = $clog2(WAIT_SLOTS);
  localparam int CntW = $clog2(WAIT_SLOTS + 1);
  localparam int WcW  = awla_pkg::WAKE_CNT_W;

  awla_pkg::state_t     state_r, state_nxt;
  awla_pkg::pick_mode_t mode_r, mode_nxt;
  awla_pkg::in_item_t   item_r;
  logic                 pick_en_r, pick_en_nxt;
  logic                 dec_en_r, dec_en_nxt;
  logic [IdxW-1:0]      dec_rank_r, dec_rank_nxt;
  logic [IdxW-1:0]      idx_r, idx_nxt;
  logic [CntW-1:0]      count_r, count_nxt;
  logic [WcW-1:0]       n_r, n_nxt;
  logic                 held_r, held_nxt;
  logic [7:0]           held_thr_r, held_thr_nxt;
  logic                 out_valid_r, out_valid_nxt;
  awla_pkg::out_item_t  out_r, out_nxt;

  logic                 accept;
  logic [WcW-1:0]       n_inc;
  logic                 in_less;
  logic                 in_timed;
  logic                 item_timed;
  logic                 item_dec;

  awla_pkg::store_cmd_t cmd;
  awla_pkg::pick_ctl_t  ctl;

  logic                 rd_vld;
  logic [IdxW-1:0]      rd_idx;
  logic                 rd_valid_bit;
  awla_pkg::slot_data_t rd_data;
  logic [IdxW-1:0]      rd_rank;
  logic                 found;
  logic [IdxW-1:0]      best_idx;
  awla_pkg::slot_data_t best_data;
  logic [IdxW-1:0]      best_rank;
  logic                 wb_en;
  logic [IdxW-1:0]      wb_rank;
  awla_pkg::slot_data_t ins_data;

  function automatic awla_pkg::out_item_t make_out(
    input logic [1:0]  status,
    input logic        waits,
    input logic        wr,
    input logic [31:0] wval,
    input logic        wv,
    input logic [7:0]  wt,
    input logic        last
  );
    awla_pkg::out_item_t o;
    o.status             = status;
    o.thread_waits       = waits;
    o.memory_write       = wr;
    o.memory_write_value = $signed(wval);
    o.woken_valid        = wv;
    o.woken_thread       = wt;
    o.last               = last;
    return o;
  endfunction

  assign accept     = start && !busy;
  assign busy       = (state_r != awla_pkg::S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_item   = out_r;
  assign n_inc      = n_r + WcW'(1);
  assign in_less    = $signed(in_item.memory_word) < $signed(in_item.compare_value);
  assign in_timed   = (in_item.opcode == awla_pkg::OP_WAIT_LT_TO) ||
                      (in_item.opcode == awla_pkg::OP_DEC_WAIT_LT_TO);
  assign item_timed = (item_r.opcode == awla_pkg::OP_WAIT_LT_TO) ||
                      (item_r.opcode == awla_pkg::OP_DEC_WAIT_LT_TO);
  assign item_dec   = (item_r.opcode == awla_pkg::OP_DEC_WAIT_LT) ||
                      (item_r.opcode == awla_pkg::OP_DEC_WAIT_LT_TO);

  assign ins_data.thread  = item_r.thread_id;
  assign ins_data.address = item_r.address;
  assign ins_data.prio    = item_r.thread_priority;

  // Sequencer: next state, pass setup and result assembly
  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    pick_en_nxt   = pick_en_r;
    dec_en_nxt    = dec_en_r;
    dec_rank_nxt  = dec_rank_r;
    idx_nxt       = idx_r;
    count_nxt     = count_r;
    n_nxt         = n_r;
    held_nxt      = held_r;
    held_thr_nxt  = held_thr_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    cmd.rd_en     = 1'b0;
    cmd.ins_en    = 1'b0;
    cmd.clr_en    = 1'b0;

    unique case (state_r)
      awla_pkg::S_IDLE: begin
        if (accept) begin
          idx_nxt    = '0;
          dec_en_nxt = 1'b0;
          n_nxt      = '0;
          held_nxt   = 1'b0;
          unique case (in_item.opcode) inside
            awla_pkg::OP_SIGNAL: begin
              mode_nxt    = in_item.compare_value[31] ? awla_pkg::PM_ARRIVAL
                                                      : awla_pkg::PM_PRIO;
              pick_en_nxt = in_item.compare_value[31] || (in_item.compare_value != 0);
              state_nxt   = awla_pkg::S_SCAN;
            end
            awla_pkg::OP_WAIT_LT, awla_pkg::OP_WAIT_LT_TO,
            awla_pkg::OP_DEC_WAIT_LT, awla_pkg::OP_DEC_WAIT_LT_TO: begin
              if (in_less) begin
                mode_nxt    = awla_pkg::PM_FREE;
                pick_en_nxt = 1'b1;
                state_nxt   = awla_pkg::S_SCAN;
              end else begin
                out_valid_nxt = 1'b1;
                out_nxt = make_out(in_timed ? awla_pkg::STS_TIMEOUT
                                            : awla_pkg::STS_SUCCESS,
                                   1'b0, 1'b0, 32'd0, 1'b0, 8'd0, 1'b1);
              end
            end
            awla_pkg::OP_TIMEOUT: begin
              mode_nxt    = awla_pkg::PM_THREAD;
              pick_en_nxt = 1'b1;
              state_nxt   = awla_pkg::S_SCAN;
            end
            default: begin
              out_valid_nxt = 1'b1;
              out_nxt = make_out(awla_pkg::STS_INVALID, 1'b0, 1'b0, 32'd0,
                                 1'b0, 8'd0, 1'b1);
            end
          endcase
        end
      end

      // One slot read per cycle
      awla_pkg::S_SCAN: begin
        cmd.rd_en = 1'b1;
        idx_nxt   = idx_r + IdxW'(1);
        if (idx_r == IdxW'(WAIT_SLOTS - 1)) begin
          state_nxt = awla_pkg::S_LAST;
        end
      end

      // Last read data reaches the pick unit
      awla_pkg::S_LAST: begin
        state_nxt = awla_pkg::S_DECIDE;
      end

      awla_pkg::S_DECIDE: begin
        idx_nxt = '0;
        unique case (mode_r) inside
          awla_pkg::PM_FREE: begin
            out_valid_nxt = 1'b1;
            state_nxt     = awla_pkg::S_IDLE;
            if (found) begin
              cmd.ins_en = 1'b1;
              count_nxt  = count_r + CntW'(1);
              out_nxt = make_out(item_timed ? awla_pkg::STS_TIMEOUT
                                            : awla_pkg::STS_SUCCESS,
                                 1'b1, item_dec,
                                 item_dec ? 32'(item_r.memory_word - 32'sd1) : 32'd0,
                                 1'b0, 8'd0, 1'b1);
            end else begin
              out_nxt = make_out(awla_pkg::STS_FULL, 1'b0, 1'b0, 32'd0,
                                 1'b0, 8'd0, 1'b1);
            end
          end
          awla_pkg::PM_THREAD: begin
            if (found) begin
              cmd.clr_en   = 1'b1;
              count_nxt    = count_r - CntW'(1);
              dec_en_nxt   = 1'b1;
              dec_rank_nxt = best_rank;
              state_nxt    = awla_pkg::S_SCAN;
            end else begin
              dec_en_nxt    = 1'b0;
              out_valid_nxt = 1'b1;
              out_nxt = make_out(awla_pkg::STS_SUCCESS, 1'b0, 1'b0, 32'd0,
                                 1'b0, 8'd0, 1'b1);
              state_nxt     = awla_pkg::S_IDLE;
            end
          end
          awla_pkg::PM_PRIO, awla_pkg::PM_ARRIVAL: begin
            if (found && pick_en_r) begin
              cmd.clr_en   = 1'b1;
              count_nxt    = count_r - CntW'(1);
              dec_en_nxt   = 1'b1;
              dec_rank_nxt = best_rank;
              // Previous pick is not the last one
              if (held_r) begin
                out_valid_nxt = 1'b1;
                out_nxt = make_out(awla_pkg::STS_SUCCESS, 1'b0, 1'b0, 32'd0,
                                   1'b1, held_thr_r, 1'b0);
              end
              held_nxt     = 1'b1;
              held_thr_nxt = best_data.thread;
              n_nxt        = n_inc;
              pick_en_nxt  = (n_inc < WcW'(awla_pkg::MAX_RESULTS)) &&
                             ((mode_r == awla_pkg::PM_ARRIVAL) ||
                              ({{(32-WcW){1'b0}}, n_inc} <
                               $unsigned(item_r.compare_value)));
              state_nxt    = awla_pkg::S_SCAN;
            end else begin
              dec_en_nxt    = 1'b0;
              out_valid_nxt = 1'b1;
              out_nxt = make_out(awla_pkg::STS_SUCCESS, 1'b0, 1'b0, 32'd0,
                                 held_r, held_r ? held_thr_r : 8'd0, 1'b1);
              state_nxt     = awla_pkg::S_IDLE;
            end
          end
          default: begin
            state_nxt = awla_pkg::S_IDLE;
          end
        endcase
      end

      default: begin
        state_nxt = awla_pkg::S_IDLE;
      end
    endcase

    // Pick unit control for the coming pass
    ctl.clear   = (state_nxt == awla_pkg::S_SCAN) && (state_r != awla_pkg::S_SCAN);
    ctl.mode    = mode_r;
    ctl.pick_en = pick_en_r;
    ctl.dec_en  = dec_en_r;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= awla_pkg::S_IDLE;
      mode_r      <= awla_pkg::PM_FREE;
      pick_en_r   <= 1'b0;
      dec_en_r    <= 1'b0;
      dec_rank_r  <= '0;
      idx_r       <= '0;
      count_r     <= '0;
      n_r         <= '0;
      held_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      pick_en_r   <= pick_en_nxt;
      dec_en_r    <= dec_en_nxt;
      dec_rank_r  <= dec_rank_nxt;
      idx_r       <= idx_nxt;
      count_r     <= count_nxt;
      n_r         <= n_nxt;
      held_r      <= held_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
    held_thr_r <= held_thr_nxt;
    out_r      <= out_nxt;
  end

  awla_slot_store #(
    .WAIT_SLOTS (WAIT_SLOTS)
  ) u_store (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .rd_idx         (idx_r),
    .ins_idx        (best_idx),
    .ins_data       (ins_data),
    .ins_rank       (count_r[IdxW-1:0]),
    .clr_idx        (best_idx),
    .wb_en          (wb_en),
    .wb_idx         (rd_idx),
    .wb_rank        (wb_rank),
    .rd_vld_r       (rd_vld),
    .rd_idx_r       (rd_idx),
    .rd_valid_bit_r (rd_valid_bit),
    .rd_data_r      (rd_data),
    .rd_rank_r      (rd_rank)
  );

  awla_pick_unit #(
    .WAIT_SLOTS (WAIT_SLOTS)
  ) u_pick (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .data_vld    (rd_vld),
    .rd_idx      (rd_idx),
    .e_valid     (rd_valid_bit),
    .e_data      (rd_data),
    .e_rank      (rd_rank),
    .key_address (item_r.address),
    .key_thread  (item_r.thread_id),
    .dec_rank    (dec_rank_r),
    .found_r     (found),
    .best_idx_r  (best_idx),
    .best_data_r (best_data),
    .best_rank_r (best_rank),
    .wb_en       (wb_en),
    .wb_rank     (wb_rank)
  );

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int LIST_DEPTH    = 16;
  localparam int RANDOM_CALLS  = 455;
  localparam int PAUSE_AT      = 240;
  localparam int DRAIN_CYCLES  = (awla_pkg::MAX_RESULTS + 1) * (LIST_DEPTH + 2) + 40;
  localparam int SHOWN_ERRORS  = 10;

  // Opcode values the block must refuse
  localparam logic [2:0] OP_UNUSED_LO = 3'd6;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;

  // Tracks the wait list and queues the results each call should produce
  class wake_tracker;
    bit                  w_valid [LIST_DEPTH];
    logic [7:0]          w_thread[LIST_DEPTH];
    logic [31:0]         w_addr  [LIST_DEPTH];
    logic [5:0]          w_prio  [LIST_DEPTH];
    int                  w_rank  [LIST_DEPTH];
    awla_pkg::out_item_t expected_outcomes[$];
    int mismatches, results_seen, calls, signals, queued, refused, woken;

    function new();
      foreach (w_valid[i]) w_valid[i] = 1'b0;
      mismatches = 0;
      results_seen = 0;
      calls = 0;
      signals = 0;
      queued = 0;
      refused = 0;
      woken = 0;
    endfunction

    function int outstanding();
      return expected_outcomes.size();
    endfunction

    // Lowest priority value first, earliest arrival on ties (or arrival only)
    function int pick_waiter(logic [31:0] addr, bit by_prio);
      int best;
      best = -1;
      for (int i = 0; i < LIST_DEPTH; i++) begin
        if (!w_valid[i] || w_addr[i] != addr) continue;
        if (best < 0) best = i;
        else if (by_prio && w_prio[i] != w_prio[best]) begin
          if (w_prio[i] < w_prio[best]) best = i;
        end else if (w_rank[i] < w_rank[best]) begin
          best = i;
        end
      end
      return best;
    endfunction

    // Free a slot and close the gap in arrival ranks
    function void drop_waiter(int s);
      int r;
      r = w_rank[s];
      w_valid[s] = 1'b0;
      for (int i = 0; i < LIST_DEPTH; i++)
        if (w_valid[i] && w_rank[i] > r) w_rank[i]--;
    endfunction

    function void accept_call(awla_pkg::in_item_t it);
      awla_pkg::out_item_t r;
      int                  n, s, slot, used;
      bit                  wake_all, timed, less;
      r = '0;
      r.last = 1'b1;
      calls++;
      case (it.opcode)
        awla_pkg::OP_SIGNAL: begin
          signals++;
          wake_all = it.compare_value[31];
          n = 0;
          while (n < awla_pkg::MAX_RESULTS && (wake_all || n < it.compare_value)) begin
            s = pick_waiter(it.address, !wake_all);
            if (s < 0) break;
            r = '0;
            r.woken_valid = 1'b1;
            r.woken_thread = w_thread[s];
            expected_outcomes.push_back(r);
            drop_waiter(s);
            n++;
          end
          woken += n;
          if (n == 0) begin
            r = '0;
          end else begin
            r = expected_outcomes.pop_back();
          end
          r.last = 1'b1;
          expected_outcomes.push_back(r);
        end
        awla_pkg::OP_WAIT_LT, awla_pkg::OP_WAIT_LT_TO,
        awla_pkg::OP_DEC_WAIT_LT, awla_pkg::OP_DEC_WAIT_LT_TO: begin
          timed = (it.opcode == awla_pkg::OP_WAIT_LT_TO ||
                   it.opcode == awla_pkg::OP_DEC_WAIT_LT_TO);
          less = $signed(it.memory_word) < $signed(it.compare_value);
          r.status = timed ? awla_pkg::STS_TIMEOUT : awla_pkg::STS_SUCCESS;
          if (less) begin
            slot = -1;
            used = 0;
            for (int i = 0; i < LIST_DEPTH; i++) begin
              if (w_valid[i]) used++;
              else if (slot < 0) slot = i;
            end
            if (slot < 0) begin
              r.status = awla_pkg::STS_FULL;
              refused++;
            end else begin
              w_valid[slot] = 1'b1;
              w_thread[slot] = it.thread_id;
              w_addr[slot] = it.address;
              w_prio[slot] = it.thread_priority;
              w_rank[slot] = used;
              r.thread_waits = 1'b1;
              queued++;
              if (it.opcode == awla_pkg::OP_DEC_WAIT_LT ||
                  it.opcode == awla_pkg::OP_DEC_WAIT_LT_TO) begin
                r.memory_write = 1'b1;
                r.memory_write_value = it.memory_word - 32'sd1;
              end
            end
          end
          expected_outcomes.push_back(r);
        end
        awla_pkg::OP_TIMEOUT: begin
          for (int i = 0; i < LIST_DEPTH; i++)
            if (w_valid[i] && w_thread[i] == it.thread_id) drop_waiter(i);
          expected_outcomes.push_back(r);
        end
        default: begin
          r.status = awla_pkg::STS_INVALID;
          expected_outcomes.push_back(r);
        end
      endcase
    endfunction

    function string fmt(awla_pkg::out_item_t o);
      return $sformatf("sts=%0d waits=%0b wr=%0b val=%h wv=%0b thr=%0d last=%0b",
                       o.status, o.thread_waits, o.memory_write, o.memory_write_value,
                       o.woken_valid, o.woken_thread, o.last);
    endfunction

    function void check_outcome(awla_pkg::out_item_t got);
      awla_pkg::out_item_t want;
      string               bad;
      results_seen++;
      if (expected_outcomes.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOWN_ERRORS)
          $display("[%0t] ERROR: result with nothing expected: %s", $time, fmt(got));
        return;
      end
      want = expected_outcomes.pop_front();
      bad = "";
      if (got.status != want.status) bad = {bad, " status"};
      if (got.thread_waits != want.thread_waits) bad = {bad, " thread_waits"};
      if (got.memory_write != want.memory_write) bad = {bad, " memory_write"};
      if (got.memory_write_value != want.memory_write_value)
        bad = {bad, " memory_write_value"};
      if (got.woken_valid != want.woken_valid) bad = {bad, " woken_valid"};
      if (got.woken_thread != want.woken_thread) bad = {bad, " woken_thread"};
      if (got.last != want.last) bad = {bad, " last"};
      if (bad != "") begin
        mismatches++;
        if (mismatches <= SHOWN_ERRORS) begin
          $display("[%0t] ERROR: field mismatch:%s", $time, bad);
          $display("  expected %s", fmt(want));
          $display("  actual   %s", fmt(got));
        end
      end
    endfunction

    // Anything still queued at the end was never produced
    function void flush_leftover();
      if (expected_outcomes.size() != 0) begin
        mismatches++;
        $display("ERROR: %0d expected results never arrived", expected_outcomes.size());
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n;
  logic                start;
  logic                busy;
  awla_pkg::in_item_t  in_item;
  logic                out_valid;
  awla_pkg::out_item_t out_item;

  wake_tracker sb;

  always #5 clk = ~clk;

  address_wait_list_arbiter_unit #(
    .WAIT_SLOTS(LIST_DEPTH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_outcome(out_item);
  end

  function automatic awla_pkg::in_item_t make_call(logic [2:0] op, logic [7:0] tid,
                                                   logic [5:0] pr, logic [31:0] addr,
                                                   logic [31:0] cmp, logic [31:0] mem);
    awla_pkg::in_item_t it;
    it.opcode = op;
    it.thread_id = tid;
    it.thread_priority = pr;
    it.address = addr;
    it.compare_value = cmp;
    it.memory_word = mem;
    return it;
  endfunction

  // Mostly short gaps, a few long ones, none inside a burst
  function automatic int pick_gap(bit burst);
    int roll;
    roll = $urandom_range(0, 99);
    if (burst || roll < 45) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // One transfer: stay idle for the gap, then hold start until busy is low
  task automatic send_call(awla_pkg::in_item_t it, int gap);
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.accept_call(it);
  endtask

  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  task automatic issue(logic [2:0] op, logic [7:0] tid, logic [5:0] pr,
                       logic [31:0] addr, logic [31:0] cmp, logic [31:0] mem);
    send_call(make_call(op, tid, pr, addr, cmp, mem), pick_gap(1'b0));
  endtask

  // Directed cases: empty list, refusals, wraps, ordering, full list
  task automatic run_directed();
    logic [31:0] hi_addr, lo_addr;
    hi_addr = 32'hFFFF_FFFF;
    lo_addr = 32'h0000_0000;
    issue(awla_pkg::OP_SIGNAL, 8'd1, 6'd0, lo_addr, 32'd1, 32'd0);
    issue(OP_UNUSED_LO, 8'd2, 6'd1, lo_addr, 32'd0, 32'd0);
    issue(OP_UNUSED_HI, 8'd3, 6'd2, hi_addr, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue(awla_pkg::OP_WAIT_LT, 8'd4, 6'd3, lo_addr, 32'd0, 32'd0);
    issue(awla_pkg::OP_WAIT_LT_TO, 8'd5, 6'd4, hi_addr, 32'h8000_0000, 32'h7FFF_FFFF);
    // four threads on the high address, one of them twice
    issue(awla_pkg::OP_DEC_WAIT_LT, 8'd0, 6'd63, hi_addr, 32'h7FFF_FFFF, 32'h8000_0000);
    issue(awla_pkg::OP_WAIT_LT, 8'd10, 6'd0, hi_addr, 32'd5, 32'd4);
    issue(awla_pkg::OP_WAIT_LT_TO, 8'd11, 6'd0, hi_addr, 32'd5, 32'hFFFF_FFFF);
    issue(awla_pkg::OP_DEC_WAIT_LT_TO, 8'd12, 6'd5, hi_addr, 32'd0, 32'h8000_0001);
    issue(awla_pkg::OP_WAIT_LT, 8'd10, 6'd20, hi_addr, 32'd1, 32'd0);
    // fill the rest of the list on the low address
    issue(awla_pkg::OP_WAIT_LT, 8'd255, 6'($urandom_range(0, 63)), lo_addr, 32'd9, 32'd3);
    for (int i = 0; i < LIST_DEPTH - 6; i++)
      issue(awla_pkg::OP_DEC_WAIT_LT, 8'(20 + i), 6'($urandom_range(0, 63)), lo_addr,
            32'd100, 32'(i));
    issue(awla_pkg::OP_DEC_WAIT_LT_TO, 8'd30, 6'd1, lo_addr, 32'd100, 32'd0);
    issue(awla_pkg::OP_TIMEOUT, 8'd10, 6'd0, 32'd0, 32'd0, 32'd0);
    issue(awla_pkg::OP_SIGNAL, 8'd1, 6'd0, hi_addr, 32'd2, 32'd0);
    issue(awla_pkg::OP_SIGNAL, 8'd1, 6'd0, hi_addr, 32'd0, 32'd0);
    issue(awla_pkg::OP_SIGNAL, 8'd1, 6'd0, lo_addr, 32'hFFFF_FFFF, 32'd0);
    issue(awla_pkg::OP_TIMEOUT, 8'd200, 6'd63, 32'h1234_5678, 32'd0, 32'd0);
  endtask

  task automatic run_random();
    logic [7:0]         thr_pool[8];
    logic [31:0]        addr_pool[4];
    logic [2:0]         wait_ops[4];
    awla_pkg::in_item_t it;
    int                 roll, d;
    int                 mem;
    logic [7:0]         tid;
    logic [31:0]        addr;
    logic signed [31:0] cnt;
    wait_ops = '{awla_pkg::OP_WAIT_LT, awla_pkg::OP_WAIT_LT_TO,
                 awla_pkg::OP_DEC_WAIT_LT, awla_pkg::OP_DEC_WAIT_LT_TO};
    foreach (thr_pool[i]) thr_pool[i] = 8'($urandom_range(0, 255));
    foreach (addr_pool[i]) addr_pool[i] = $urandom;
    addr_pool[0] = 32'hFFFF_FFFF;

    for (int k = 0; k < RANDOM_CALLS; k++) begin
      if (k == PAUSE_AT) drain_results();
      roll = $urandom_range(0, 99);
      tid = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                         : thr_pool[$urandom_range(0, 7)];
      addr = ($urandom_range(0, 9) == 0) ? $urandom : addr_pool[$urandom_range(0, 3)];
      it = make_call(awla_pkg::OP_SIGNAL, tid, 6'($urandom_range(0, 63)), addr, 32'd0,
                     $urandom);

      if (roll < 48) begin
        // wait, usually with the condition true
        it.opcode = wait_ops[$urandom_range(0, 3)];
        if ($urandom_range(0, 99) < 85) begin
          mem = $urandom;
          d = $urandom_range(1, 50);
          if (mem > 2147483647 - d) mem = mem - 100;
          it.memory_word = mem;
          it.compare_value = mem + d;
        end else begin
          it.compare_value = $urandom;
        end
      end else if (roll < 78) begin
        // signal with assorted wake counts
        d = $urandom_range(0, 99);
        if (d < 40) cnt = $urandom_range(1, 3);
        else if (d < 55) cnt = 0;
        else if (d < 65) cnt = -1;
        else if (d < 75) cnt = $urandom | 32'h8000_0000;
        else if (d < 90) cnt = $urandom & 32'h7FFF_FFFF;
        else cnt = $urandom_range(16, 20);
        it.compare_value = cnt;
      end else if (roll < 88) begin
        it.opcode = awla_pkg::OP_TIMEOUT;
        it.compare_value = $urandom;
      end else if (roll < 93) begin
        it.opcode = $urandom_range(0, 1) ? OP_UNUSED_LO : OP_UNUSED_HI;
        it.compare_value = $urandom;
      end else begin
        // noise over every field
        it = make_call(3'($urandom_range(0, 7)), 8'($urandom), 6'($urandom), $urandom,
                       $urandom, $urandom);
      end
      send_call(it, pick_gap((k % 60) >= 45));
    end
  endtask

  // Main sequence
  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    sb = new();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    run_directed();
    run_random();
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.flush_leftover();

    $display("Covered %0d calls: %0d signals, %0d waits queued, %0d full-list refusals.",
             sb.calls, sb.signals, sb.queued, sb.refused);
    $display("Checked %0d results, %0d of them woken threads.", sb.results_seen, sb.woken);
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// File: sim.f
rtl/core/awla_pkg.sv
rtl/core/awla_slot_store.sv
rtl/core/awla_pick_unit.sv
rtl/core/address_wait_list_arbiter_unit.sv
tb/tb_top.sv
